// ===== rtl/zcpat_pkg.sv =====
package zcpat_pkg;

  localparam int unsigned RING_TAPS = 3;

  localparam logic [3:0] RegPowerStep  = 4'd0;
  localparam logic [3:0] RegMinPeriod  = 4'd1;
  localparam logic [3:0] RegMaxPeriod  = 4'd2;
  localparam logic [3:0] RegPulseWidth = 4'd3;

  localparam logic [5:0]  PowerMax        = 6'd50;
  localparam logic [15:0] PeriodReset     = 16'd10000;
  localparam logic [13:0] MinPeriodReset  = 14'd8500;
  localparam logic [13:0] MaxPeriodReset  = 14'd11500;
  localparam logic [9:0]  PulseWidthReset = 10'd300;
  localparam logic [13:0] DelayMax        = 14'h3FFF;

  // floor(x / 100) == (x * Recip) >> RecipShift for every x below 2^23
  localparam logic [23:0] Recip      = 24'd10737419;
  localparam int unsigned RecipShift = 30;

  typedef struct packed {
    logic [30:0] coef;
    logic [13:0] period_lo;
    logic [13:0] period_hi;
    logic [9:0]  pulse_width;
  } cfg_t;

  typedef struct packed {
    logic [15:0] interval;
    logic        accepted;
    logic [15:0] smoothed;
  } filt_t;

  function automatic logic [6:0] angle_pct(input logic [5:0] ps);
    logic [6:0] r;
    case (ps)
      6'd0:  r = 7'd100;  6'd1:  r = 7'd85;  6'd2:  r = 7'd81;  6'd3:  r = 7'd78;
      6'd4:  r = 7'd76;   6'd5:  r = 7'd74;  6'd6:  r = 7'd72;  6'd7:  r = 7'd71;
      6'd8:  r = 7'd69;   6'd9:  r = 7'd68;  6'd10: r = 7'd66;  6'd11: r = 7'd65;
      6'd12: r = 7'd64;   6'd13: r = 7'd63;  6'd14: r = 7'd61;  6'd15: r = 7'd60;
      6'd16: r = 7'd59;   6'd17: r = 7'd58;  6'd18: r = 7'd57;  6'd19: r = 7'd56;
      6'd20: r = 7'd55;   6'd21: r = 7'd54;  6'd22: r = 7'd53;  6'd23: r = 7'd52;
      6'd24: r = 7'd51;   6'd25: r = 7'd50;  6'd26: r = 7'd49;  6'd27: r = 7'd48;
      6'd28: r = 7'd47;   6'd29: r = 7'd46;  6'd30: r = 7'd45;  6'd31: r = 7'd44;
      6'd32: r = 7'd43;   6'd33: r = 7'd42;  6'd34: r = 7'd41;  6'd35: r = 7'd40;
      6'd36: r = 7'd39;   6'd37: r = 7'd37;  6'd38: r = 7'd36;  6'd39: r = 7'd35;
      6'd40: r = 7'd34;   6'd41: r = 7'd32;  6'd42: r = 7'd31;  6'd43: r = 7'd29;
      6'd44: r = 7'd28;   6'd45: r = 7'd26;  6'd46: r = 7'd24;  6'd47: r = 7'd22;
      6'd48: r = 7'd19;   6'd49: r = 7'd15;  6'd50: r = 7'd0;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // percentage folded together with the divide-by-100 reciprocal
  function automatic logic [30:0] coef_of(input logic [5:0] ps);
    logic [30:0] p;
    p = {24'd0, angle_pct(ps)};
    return p * {7'd0, Recip};
  endfunction

endpackage

// ===== rtl/zcpat_cfg_regs.sv =====
module zcpat_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [3:0]          wr_index_i,
  input  logic [13:0]         wr_data_i,
  output zcpat_pkg::cfg_t     cfg_o,
  output logic                pend_set_o
);
  import zcpat_pkg::*;

  cfg_t cfg_q;
  logic power_ok;

  assign power_ok = (wr_data_i[5:0] <= PowerMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef        <= coef_of(6'd0);
      cfg_q.period_lo   <= MinPeriodReset;
      cfg_q.period_hi   <= MaxPeriodReset;
      cfg_q.pulse_width <= PulseWidthReset;
    end else if (wr_en_i) begin
      case (wr_index_i)
        RegPowerStep: begin
          if (power_ok) cfg_q.coef <= coef_of(wr_data_i[5:0]);
        end
        RegMinPeriod:  cfg_q.period_lo   <= wr_data_i;
        RegMaxPeriod:  cfg_q.period_hi   <= wr_data_i;
        RegPulseWidth: cfg_q.pulse_width <= wr_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign pend_set_o = wr_en_i && (wr_index_i == RegPowerStep) && power_ok;
  assign cfg_o      = cfg_q;

endmodule

// ===== rtl/zcpat_filter.sv =====
module zcpat_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [15:0]         stamp_i,
  input  zcpat_pkg::cfg_t     cfg_i,
  output zcpat_pkg::filt_t    filt_o
);
  import zcpat_pkg::*;

  logic [15:0] prev_q;
  logic [15:0] ring_q [RING_TAPS];
  logic [15:0] ring_d [RING_TAPS];
  logic [1:0]  ptr_q, ptr_d;
  logic [15:0] smooth_q;
  logic [15:0] interval;
  logic        in_window;
  logic [15:0] lo_ab, hi_ab, lo_hc, med;
  logic [17:0] blend_sum;

  assign interval  = stamp_i - prev_q;
  assign in_window = (interval >= {2'b00, cfg_i.period_lo}) &&
                     (interval <= {2'b00, cfg_i.period_hi});

  always_comb begin
    for (int i = 0; i < RING_TAPS; i++) begin
      ring_d[i] = (ptr_q == 2'(i)) ? interval : ring_q[i];
    end
  end

  assign ptr_d = (ptr_q == 2'(RING_TAPS - 1)) ? 2'd0 : ptr_q + 2'd1;

  // median of three
  assign lo_ab = (ring_d[0] < ring_d[1]) ? ring_d[0] : ring_d[1];
  assign hi_ab = (ring_d[0] < ring_d[1]) ? ring_d[1] : ring_d[0];
  assign lo_hc = (hi_ab < ring_d[2]) ? hi_ab : ring_d[2];
  assign med   = (lo_ab > lo_hc) ? lo_ab : lo_hc;

  assign blend_sum = {2'b00, smooth_q} + {1'b0, smooth_q, 1'b0} + {2'b00, med};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      ptr_q    <= '0;
      smooth_q <= PeriodReset;
      for (int i = 0; i < RING_TAPS; i++) ring_q[i] <= PeriodReset;
    end else if (fire_i) begin
      prev_q <= stamp_i;
      if (in_window) begin
        ptr_q    <= ptr_d;
        smooth_q <= blend_sum[17:2];
        for (int i = 0; i < RING_TAPS; i++) ring_q[i] <= ring_d[i];
      end
    end
  end

  assign filt_o.interval = interval;
  assign filt_o.accepted = in_window;
  assign filt_o.smoothed = blend_sum[17:2];

endmodule

// ===== rtl/zcpat_delay.sv =====
module zcpat_delay (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                pend_set_i,
  input  zcpat_pkg::cfg_t     cfg_i,
  input  zcpat_pkg::filt_t    filt_i,
  output logic                updated_o,
  output logic [13:0]         delay_o,
  output logic [14:0]         reload_o
);
  import zcpat_pkg::*;

  logic [15:0] applied_q;
  logic        pending_q;
  logic [13:0] delay_q;
  logic [14:0] reload_q;
  logic [46:0] prod;
  logic [15:0] quot;
  logic [13:0] delay_d;
  logic [14:0] reload_d;
  logic        need;

  assign prod     = {31'd0, filt_i.smoothed} * {16'd0, cfg_i.coef};
  assign quot     = prod[RecipShift +: 16];
  assign delay_d  = (quot[15:14] != 2'b00) ? DelayMax : quot[13:0];
  assign reload_d = {1'b0, delay_d} + {5'd0, cfg_i.pulse_width};

  assign need = filt_i.accepted && ((filt_i.smoothed != applied_q) || pending_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_q <= PeriodReset;
      pending_q <= 1'b0;
      delay_q   <= '0;
      reload_q  <= '0;
    end else begin
      if (fire_i && need) begin
        applied_q <= filt_i.smoothed;
        delay_q   <= delay_d;
        reload_q  <= reload_d;
      end
      if (pend_set_i) begin
        pending_q <= 1'b1;
      end else if (fire_i && need) begin
        pending_q <= 1'b0;
      end
    end
  end

  assign updated_o = need;
  assign delay_o   = need ? delay_d : delay_q;
  assign reload_o  = need ? reload_d : reload_q;

endmodule

// ===== rtl/zero_cross_phase_angle_timer_core.sv =====
// Zero-crossing phase-angle timer. Each zero-crossing timestamp produces exactly one result,
// in order, carrying the interval to the previous crossing, whether it passed the period
// window, whether the fire delay was recomputed, and the current fire delay and reload.
// An event is registered in the input register on acceptance and its result is registered
// in the result register when the event moves on; one event is taken every cycle while the
// result register is not stalled, as the interval ring, smoothed period and delay registers update together.
// A full result register that is stalled holds the input register, which then stalls the
// input. Register writes are always taken (cfg_ready_o stays high) and must be issued while
// no event is in flight. Power levels above 50 are ignored.
module zero_cross_phase_angle_timer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] interval_o,
  output logic        accepted_o,
  output logic        updated_o,
  output logic [13:0] fire_delay_o,
  output logic [14:0] reload_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);
  import zcpat_pkg::*;

  logic        a_valid_q;
  logic [15:0] a_stamp_q;
  logic        b_valid_q;
  logic [15:0] b_interval_q;
  logic        b_accepted_q;
  logic        b_updated_q;
  logic [13:0] b_delay_q;
  logic [14:0] b_reload_q;
  logic        b_ready;
  logic        fire;
  logic        pend_set;
  cfg_t        cfg;
  filt_t       filt;
  logic        upd;
  logic [13:0] delay_n;
  logic [14:0] reload_n;

  assign b_ready    = !b_valid_q || !out_stall_i;
  assign fire       = a_valid_q && b_ready;
  assign in_stall_o = a_valid_q && !b_ready;
  assign cfg_ready_o = 1'b1;

  zcpat_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .pend_set_o (pend_set)
  );

  zcpat_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .stamp_i (a_stamp_q),
    .cfg_i   (cfg),
    .filt_o  (filt)
  );

  zcpat_delay u_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .pend_set_i (pend_set),
    .cfg_i      (cfg),
    .filt_i     (filt),
    .updated_o  (upd),
    .delay_o    (delay_n),
    .reload_o   (reload_n)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) a_stamp_q <= timestamp_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      b_interval_q <= filt.interval;
      b_accepted_q <= filt.accepted;
      b_updated_q  <= upd;
      b_delay_q    <= delay_n;
      b_reload_q   <= reload_n;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign interval_o   = b_interval_q;
  assign accepted_o   = b_accepted_q;
  assign updated_o    = b_updated_q;
  assign fire_delay_o = b_delay_q;
  assign reload_o     = b_reload_q;

endmodule

// ===== rtl/zcpat_checker.sv =====
module zcpat_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [15:0] interval_o,
  input  logic        accepted_o,
  input  logic        updated_o,
  input  logic [13:0] fire_delay_o,
  input  logic [14:0] reload_o
);

  // a held result keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interval_o) && $stable(reload_o))
    else $error("stalled result changed");

  // only an in-window interval can trigger a recompute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && updated_o |-> accepted_o)
    else $error("update without accepted interval");

  // reload is delay plus a non-negative pulse width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, fire_delay_o} <= reload_o)
    else $error("reload below fire delay");

  // input only stalls behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind zero_cross_phase_angle_timer_core zcpat_checker u_zcpat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .interval_o   (interval_o),
  .accepted_o   (accepted_o),
  .updated_o    (updated_o),
  .fire_delay_o (fire_delay_o),
  .reload_o     (reload_o)
);

// ===== tb/zero_cross_phase_angle_timer_checker.sv =====
module zero_cross_phase_angle_timer_checker
  import zcpat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] timestamp_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] interval_i,
  input  logic        accepted_i,
  input  logic        updated_i,
  input  logic [13:0] fire_delay_i,
  input  logic [14:0] reload_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          reports_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] interval;
    logic        accepted;
    logic        updated;
    logic [13:0] fire_delay;
    logic [14:0] reload;
  } crossing_report_t;

  // firing angle in percent of the half period, indexed by power level
  localparam logic [6:0] PhasePct [51] = '{
    7'd100, 7'd85, 7'd81, 7'd78, 7'd76, 7'd74, 7'd72, 7'd71, 7'd69, 7'd68,
    7'd66,  7'd65, 7'd64, 7'd63, 7'd61, 7'd60, 7'd59, 7'd58, 7'd57, 7'd56,
    7'd55,  7'd54, 7'd53, 7'd52, 7'd51, 7'd50, 7'd49, 7'd48, 7'd47, 7'd46,
    7'd45,  7'd44, 7'd43, 7'd42, 7'd41, 7'd40, 7'd39, 7'd37, 7'd36, 7'd35,
    7'd34,  7'd32, 7'd31, 7'd29, 7'd28, 7'd26, 7'd24, 7'd22, 7'd19, 7'd15,
    7'd0
  };

  logic [5:0]  power_lvl;
  logic [13:0] window_lo;
  logic [13:0] window_hi;
  logic [9:0]  gate_width;

  logic [15:0] prev_stamp;
  logic [15:0] period_ring [RING_TAPS];
  logic [1:0]  ring_wr;
  logic [15:0] period_avg;
  logic [15:0] period_applied;
  logic        power_dirty;
  logic [13:0] delay_now;
  logic [14:0] reload_now;

  crossing_report_t pending_reports [$];
  int mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic logic [15:0] median3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  task automatic apply_reg_write(input logic [3:0] idx, input logic [13:0] data);
    case (idx)
      RegPowerStep: begin
        if (data[5:0] <= PowerMax) begin
          power_lvl = data[5:0];
          power_dirty = 1'b1;
        end
      end
      RegMinPeriod:  window_lo = data;
      RegMaxPeriod:  window_hi = data;
      RegPulseWidth: gate_width = data[9:0];
      default: ;
    endcase
  endtask

  task automatic predict_crossing(input logic [15:0] stamp, output crossing_report_t rep);
    logic [15:0] gap;
    logic [15:0] med;
    logic [17:0] blend;
    logic [22:0] scaled;
    logic [13:0] delay_new;
    rep = '0;
    gap = stamp - prev_stamp;
    prev_stamp = stamp;
    rep.interval = gap;
    if (gap >= {2'b00, window_lo} && gap <= {2'b00, window_hi}) begin
      rep.accepted = 1'b1;
      period_ring[ring_wr] = gap;
      ring_wr = (ring_wr == 2'd2) ? 2'd0 : ring_wr + 2'd1;
      med = median3(period_ring[0], period_ring[1], period_ring[2]);
      blend = ({2'b00, period_avg} * 18'd3 + {2'b00, med}) >> 2;
      period_avg = blend[15:0];
      if (period_avg != period_applied || power_dirty) begin
        scaled = 23'(period_avg) * 23'(PhasePct[power_lvl]) / 23'd100;
        delay_new = (scaled > 23'd16383) ? 14'h3FFF : scaled[13:0];
        delay_now = delay_new;
        reload_now = 15'(delay_new) + 15'(gate_width);
        period_applied = period_avg;
        power_dirty = 1'b0;
        rep.updated = 1'b1;
      end
    end
    rep.fire_delay = delay_now;
    rep.reload = reload_now;
  endtask

  task automatic check_report(input crossing_report_t got);
    crossing_report_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with nothing expected: interval %0d acc %0b upd %0b delay %0d reload %0d",
                 $time, got.interval, got.accepted, got.updated, got.fire_delay, got.reload);
      end
    end else begin
      want = pending_reports.pop_front();
      if (got.interval != want.interval || got.accepted != want.accepted ||
          got.updated != want.updated || got.fire_delay != want.fire_delay ||
          got.reload != want.reload) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp interval %0d acc %0b upd %0b delay %0d reload %0d",
                   $time, want.interval, want.accepted, want.updated, want.fire_delay,
                   want.reload);
          $display("%0t:          got interval %0d acc %0b upd %0b delay %0d reload %0d",
                   $time, got.interval, got.accepted, got.updated, got.fire_delay,
                   got.reload);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_report_t rep;
    if (!rst_ni) begin
      power_lvl = '0;
      window_lo = MinPeriodReset;
      window_hi = MaxPeriodReset;
      gate_width = PulseWidthReset;
      prev_stamp = '0;
      foreach (period_ring[k]) period_ring[k] = PeriodReset;
      ring_wr = '0;
      period_avg = PeriodReset;
      period_applied = PeriodReset;
      power_dirty = 1'b0;
      delay_now = '0;
      reload_now = '0;
      pending_reports.delete();
      reports_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg_write(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        check_report({interval_i, accepted_i, updated_i, fire_delay_i, reload_i});
      end
      if (in_valid_i && !in_stall_i) begin
        predict_crossing(timestamp_i, rep);
        pending_reports.push_back(rep);
      end
      reports_due_o <= pending_reports.size();
    end
  end

endmodule

// ===== tb/tb_zero_cross_phase_angle_timer_core.sv =====
module tb_zero_cross_phase_angle_timer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import zcpat_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 80;

  localparam logic [3:0] RegFirstUnused = 4'd4;
  localparam logic [3:0] RegTopIndex    = 4'd15;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] timestamp = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] interval;
  logic        accepted;
  logic        updated;
  logic [13:0] fire_delay;
  logic [14:0] reload;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;

  logic        hold_req = 1'b0;
  logic        quiet_stretch = 1'b0;
  int          mismatch_count;
  int          reports_due;

  logic [15:0] stamp_now = '0;
  logic [13:0] win_lo = MinPeriodReset;
  logic [13:0] win_hi = MaxPeriodReset;

  always #2 clk = ~clk;

  zero_cross_phase_angle_timer_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .timestamp_i  (timestamp),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .interval_o   (interval),
    .accepted_o   (accepted),
    .updated_o    (updated),
    .fire_delay_o (fire_delay),
    .reload_o     (reload),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  zero_cross_phase_angle_timer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .timestamp_i      (timestamp),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .interval_i       (interval),
    .accepted_i       (accepted),
    .updated_i        (updated),
    .fire_delay_i     (fire_delay),
    .reload_i         (reload),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due)
  );

  task automatic send_crossing(input logic [15:0] stamp);
    in_valid <= 1'b1;
    timestamp <= stamp;
    stamp_now = stamp;
    do @(posedge clk); while (in_stall);
    if (!quiet_stretch && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int count);
    logic [15:0] delta;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (win_lo <= win_hi && pick < 80) begin
        delta = 16'($urandom_range(win_hi, win_lo));
      end else if (pick < 90) begin
        // just outside the window on either side
        if ($urandom_range(0, 1) == 1) begin
          delta = 16'(win_lo) - 16'($urandom_range(1, 3));
        end else begin
          delta = 16'(win_hi) + 16'($urandom_range(1, 3));
        end
      end else begin
        delta = 16'($urandom_range(0, 65535));
      end
      send_crossing(stamp_now + delta);
    end
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [13:0] power, input logic [13:0] lo,
                              input logic [13:0] hi, input logic [13:0] width);
    write_reg(RegPowerStep, power);
    write_reg(RegMinPeriod, lo);
    write_reg(RegMaxPeriod, hi);
    write_reg(RegPulseWidth, width);
    cfg_valid <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 20);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [13:0] lo;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default window: first crossing against zero, window edges, wrap and extremes
    send_crossing(16'd10000);
    send_crossing(16'd20000);
    send_crossing(16'd28499);
    send_crossing(16'd36999);
    send_crossing(16'd48499);
    send_crossing(16'd60000);
    send_crossing(16'd60000);
    send_crossing(16'd59999);
    send_crossing(16'hFFFF);
    send_crossing(16'h0000);
    send_crossing(16'd10000);
    drain_events();

    // power write stays pending across a rejected interval
    write_reg(RegPowerStep, 14'd25);
    cfg_valid <= 1'b0;
    send_crossing(16'd30000);
    send_crossing(16'd40000);
    drain_events();

    // power levels 51 and 63 and unused indexes are dropped; 14'h3FC5 is taken as level 5
    write_reg(RegPowerStep, 14'd51);
    write_reg(RegPowerStep, 14'd63);
    write_reg(RegPowerStep, 14'h3FC5);
    write_reg(RegFirstUnused, 14'($urandom_range(0, 16383)));
    write_reg(RegTopIndex, 14'h3FFF);
    cfg_valid <= 1'b0;
    send_crossing(16'd50000);
    drain_events();

    // full window, zero delay at top power, widest pulse
    program_regs(14'd50, 14'd0, 14'd16383, 14'd1023);
    send_crossing(stamp_now + 16'd16383);
    send_crossing(stamp_now);
    send_crossing(stamp_now + 16'd1);
    drain_events();

    // empty window
    program_regs(14'd10, 14'd12000, 14'd3000, 14'd0);
    send_crossing(stamp_now + 16'd5000);
    send_crossing(stamp_now + 16'd12000);
    send_crossing(stamp_now + 16'd3000);
    drain_events();

    program_regs(14'd0, MinPeriodReset, MaxPeriodReset, PulseWidthReset);
    send_random(150);
    drain_events();

    program_regs(14'd50, 14'd0, 14'd16383, 14'd1023);
    send_random(150);
    drain_events();

    program_regs(14'($urandom_range(1, 49)), 14'd9000, 14'd11000, 14'($urandom_range(0, 16383)));
    send_random(50);
    hold_req <= 1'b1;
    send_random(50);
    quiet_stretch <= 1'b1;
    send_random(100);
    quiet_stretch <= 1'b0;
    drain_events();

    program_regs(14'd49, 14'd16383, 14'd16383, 14'd0);
    send_random(120);
    drain_events();

    program_regs(14'($urandom_range(0, 16383)), 14'd12000, 14'd3000,
                 14'($urandom_range(0, 16383)));
    send_random(80);
    drain_events();

    for (int ph = 0; ph < 3; ph++) begin
      lo = 14'($urandom_range(0, 14000));
      program_regs(14'($urandom_range(0, 16383)), lo,
                   lo + 14'($urandom_range(0, 16383 - lo)), 14'($urandom_range(0, 16383)));
      send_random(100);
      drain_events();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
